[src/tlv_fx_pkg.sv]
// ----------------------------------------------------------------------------
// tlv_fx_pkg
// Shared types and codes of the TLV field extractor.
// ----------------------------------------------------------------------------
package tlv_fx_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CAP_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned RQ_DEPTH  = 4;
  localparam int unsigned RQ_PTR_W  = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_VALUE  = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_OVERRUN  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_TAG   = 1'b0,
    CFG_OUT_CAPACITY = 1'b1
  } cfg_idx_t;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

[src/tlv_fx_if.sv]
// ----------------------------------------------------------------------------
// tlv_in_if / tlv_out_if
// Valid/ready channels for input bytes and extraction results.
// ----------------------------------------------------------------------------
interface tlv_in_if import tlv_fx_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface tlv_out_if import tlv_fx_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output kind, output out_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input status,
                  input last, output ready);
endinterface

[src/tlv_field_extractor_top.sv]
// ----------------------------------------------------------------------------
// tlv_field_extractor_top
// Streams the value of the first TLV record whose type matches target_tag.
//
//   channel  dir  payload                          handshake
//   in_ch    in   data_byte[7:0], region_end       valid/ready
//   out_ch   out  kind, out_byte[7:0], status, last valid/ready
//   cfg_*    in   cfg_index[0], cfg_wdata[12:0]    cfg_we, no back-pressure
//
// One byte is accepted per cycle while ready is high; its results enter a
// four-entry result queue in the same cycle and show on out_ch from the
// next cycle. in_ch.ready is high while the queue has room for two results,
// so the byte ending a record (value byte plus status) can always be taken.
// Results leave at one per cycle; stalls on out_ch fill the queue.
// rst_n is synchronous; it clears the parser, the queue and the registers.
// ----------------------------------------------------------------------------
module tlv_field_extractor_top import tlv_fx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tlv_in_if.sink               in_ch,
  tlv_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic [BYTE_W-1:0]   target_tag_r;
  logic [CAP_W-1:0]    out_capacity_r;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   length_high_r, length_high_nxt;
  logic [LEN_W-1:0]    bytes_left_r, bytes_left_nxt;
  logic                is_match_r, is_match_nxt;
  logic [CAP_W-1:0]    emitted_r, emitted_nxt;

  result_t             rq_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CNT_W-1:0] count_r;

  logic                in_acc, out_acc;
  logic                push_val, push_st, clear;
  status_t             st_code;
  logic [CAP_W-1:0]    limit;
  logic                below;
  logic [LEN_W-1:0]    len_full, left_dec;
  result_t             val_entry, st_entry;
  logic [RQ_CNT_W-1:0] push_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_tag_r   <= '0;
      out_capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET_TAG:   target_tag_r   <= cfg_wdata[BYTE_W-1:0];
        CFG_OUT_CAPACITY: out_capacity_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (count_r <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign limit       = (out_capacity_r == '0) ? '0 : out_capacity_r - CAP_W'(1);
  assign below       = (emitted_r < limit);
  assign len_full    = {length_high_r, in_ch.data_byte};
  assign left_dec    = bytes_left_r - LEN_W'(1);

  always_comb begin
    phase_nxt       = phase_r;
    length_high_nxt = length_high_r;
    bytes_left_nxt  = bytes_left_r;
    is_match_nxt    = is_match_r;
    emitted_nxt     = emitted_r;
    push_val        = 1'b0;
    push_st         = 1'b0;
    st_code         = ST_FOUND;
    clear           = 1'b0;
    if (in_acc) begin
      case (phase_r)
        PH_TYPE: begin
          is_match_nxt = (in_ch.data_byte == target_tag_r);
          phase_nxt    = PH_LEN_HI;
          if (in_ch.region_end) begin
            push_st = 1'b1;
            st_code = ST_NOTFOUND;
            clear   = 1'b1;
          end
        end
        PH_LEN_HI: begin
          length_high_nxt = in_ch.data_byte;
          phase_nxt       = PH_LEN_LO;
          if (in_ch.region_end) begin
            push_st = 1'b1;
            st_code = ST_NOTFOUND;
            clear   = 1'b1;
          end
        end
        PH_LEN_LO: begin
          bytes_left_nxt = len_full;
          emitted_nxt    = '0;
          if (len_full == '0) begin
            if (is_match_r) begin
              push_st = 1'b1;
              st_code = ST_FOUND;
              if (in_ch.region_end) clear = 1'b1;
              else phase_nxt = PH_IGNORE;
            end else if (in_ch.region_end) begin
              push_st = 1'b1;
              st_code = ST_NOTFOUND;
              clear   = 1'b1;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end else if (in_ch.region_end) begin
            push_st = 1'b1;
            st_code = ST_OVERRUN;
            clear   = 1'b1;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          bytes_left_nxt = left_dec;
          if (left_dec != '0) begin
            if (in_ch.region_end) begin
              push_st = 1'b1;
              st_code = ST_OVERRUN;
              clear   = 1'b1;
            end else if (is_match_r && below) begin
              push_val    = 1'b1;
              emitted_nxt = emitted_r + CAP_W'(1);
            end
          end else if (is_match_r) begin
            if ((in_ch.data_byte != '0) && below) begin
              push_val    = 1'b1;
              emitted_nxt = emitted_r + CAP_W'(1);
            end
            push_st = 1'b1;
            st_code = ST_FOUND;
            if (in_ch.region_end) clear = 1'b1;
            else phase_nxt = PH_IGNORE;
          end else if (in_ch.region_end) begin
            push_st = 1'b1;
            st_code = ST_NOTFOUND;
            clear   = 1'b1;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
          if (in_ch.region_end) clear = 1'b1;
        end
      endcase
      if (clear) begin
        phase_nxt       = PH_TYPE;
        length_high_nxt = '0;
        bytes_left_nxt  = '0;
        is_match_nxt    = 1'b0;
        emitted_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_TYPE;
      length_high_r <= '0;
      bytes_left_r  <= '0;
      is_match_r    <= 1'b0;
      emitted_r     <= '0;
    end else begin
      phase_r       <= phase_nxt;
      length_high_r <= length_high_nxt;
      bytes_left_r  <= bytes_left_nxt;
      is_match_r    <= is_match_nxt;
      emitted_r     <= emitted_nxt;
    end
  end

  always_comb begin
    val_entry          = '0;
    val_entry.kind     = KIND_VALUE;
    val_entry.out_byte = in_ch.data_byte;
    st_entry           = '0;
    st_entry.kind      = KIND_STATUS;
    st_entry.status    = st_code;
    st_entry.last      = 1'b1;
  end

  assign push_n  = RQ_CNT_W'(push_val) + RQ_CNT_W'(push_st);
  assign out_acc = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push_val) rq_r[wr_ptr_r] <= val_entry;
    if (push_st)  rq_r[push_val ? wr_ptr_r + RQ_PTR_W'(1) : wr_ptr_r] <= st_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[RQ_PTR_W-1:0];
      if (out_acc) rd_ptr_r <= rd_ptr_r + RQ_PTR_W'(1);
      count_r  <= count_r + push_n - RQ_CNT_W'(out_acc);
    end
  end

  assign out_ch.valid    = (count_r != '0);
  assign out_ch.kind     = rq_r[rd_ptr_r].kind;
  assign out_ch.out_byte = rq_r[rd_ptr_r].out_byte;
  assign out_ch.status   = rq_r[rd_ptr_r].status;
  assign out_ch.last     = rq_r[rd_ptr_r].last;

endmodule

[src/tlv_fx_checker.sv]
// ----------------------------------------------------------------------------
// tlv_fx_checker
// Port-level checks of the TLV field extractor, bound to the top level.
// ----------------------------------------------------------------------------
module tlv_fx_checker import tlv_fx_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_kind,
  input logic [BYTE_W-1:0]   out_byte,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == out_kind)
    else $error("last does not mark the status result");

  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VALUE |-> out_status == ST_FOUND)
    else $error("value word carries a status");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |->
      out_byte == '0 && (out_status == ST_FOUND || out_status == ST_NOTFOUND
      || out_status == ST_OVERRUN))
    else $error("bad status word");

endmodule

bind tlv_field_extractor_top tlv_fx_checker u_tlv_fx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.kind),
  .out_byte   (out_ch.out_byte),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);
